/* rtl/image_format_sniffer_unit_assert.svh */
// Assertion macros used by the image format sniffer top level.
`ifndef IMAGE_FORMAT_SNIFFER_UNIT_ASSERT_SVH
`define IMAGE_FORMAT_SNIFFER_UNIT_ASSERT_SVH

// The antecedent holds in this cycle, so the consequent must hold in the same cycle.
`define IFS_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("ifs assertion failed");

// The antecedent holds in this cycle, so the consequent must hold in the next cycle.
`define IFS_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("ifs assertion failed");

`endif

/* rtl/ifs_pkg.sv */
// Shared types, constants and brand tables for the image format sniffer.
package ifs_pkg;

  localparam int unsigned SVG_PROBE_WINDOW_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF       = 32;
  localparam int unsigned HdrLen               = 12;

  typedef enum logic [2:0] {
    FmtNone = 3'd0,
    FmtPng  = 3'd1,
    FmtJpeg = 3'd2,
    FmtWebp = 3'd3,
    FmtGif  = 3'd4,
    FmtAvif = 3'd5,
    FmtHeic = 3'd6,
    FmtSvg  = 3'd7
  } ifs_fmt_e;

  // Header test results, taken from the state as it stands after the current byte.
  typedef struct packed {
    logic png;
    logic jpeg;
    logic webp;
    logic gif;
    logic avif;
    logic heic;
  } ifs_hdr_flags_t;

  localparam logic [31:0] TagPng  = 32'h89504E47;
  localparam logic [31:0] TagRiff = 32'h52494646;
  localparam logic [31:0] TagGif8 = 32'h47494638;
  localparam logic [31:0] TagFtyp = 32'h66747970;
  localparam logic [31:0] TagSvg  = 32'h3C737667;  // "<svg"
  localparam logic [31:0] TagXml  = 32'h3F786D6C;  // "?xml"

  localparam logic [7:0] ChBom0 = 8'hEF;
  localparam logic [7:0] ChBom1 = 8'hBB;
  localparam logic [7:0] ChBom2 = 8'hBF;
  localparam logic [7:0] ChJpg0 = 8'hFF;
  localparam logic [7:0] ChJpg1 = 8'hD8;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;

  function automatic logic is_avif_brand(input logic [31:0] w);
    return (w == 32'h61766966) || (w == 32'h61766973);  // avif, avis
  endfunction

  function automatic logic is_heic_brand(input logic [31:0] w);
    return (w == 32'h68656963) || (w == 32'h68656978) ||  // heic, heix
           (w == 32'h68657663) || (w == 32'h68657678) ||  // hevc, hevx
           (w == 32'h6865696D) || (w == 32'h68656973) ||  // heim, heis
           (w == 32'h6D696631) || (w == 32'h6D736631);    // mif1, msf1
  endfunction

endpackage

/* rtl/ifs_hdr_track.sv */
// Byte counter, header bytes, four-byte window and ISO-BMFF brand tracking.
module ifs_hdr_track #(
  parameter int unsigned COUNT_BITS = ifs_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   last_i,
  input  logic [7:0]             data_byte_i,
  output logic [COUNT_BITS-1:0]  count_o,
  output logic [31:0]            window_o,
  output ifs_pkg::ifs_hdr_flags_t flags_o
);
  import ifs_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [31:0]           window_q, window_d;
  logic [1:0]            brand_q, brand_d;
  logic [7:0]            hdr_q [HdrLen];
  logic [7:0]            hdr_d [HdrLen];
  logic                  fresh, scan_hit;
  logic [31:0]           word0, word1;

  always_comb begin
    fresh    = (count_q != '1);
    count_d  = fresh ? count_q + 1'b1 : count_q;
    window_d = {window_q[23:0], data_byte_i};
    hdr_d    = hdr_q;
    if (fresh && (count_q < COUNT_BITS'(HdrLen))) begin
      hdr_d[count_q[3:0]] = data_byte_i;
    end
    word0 = {hdr_d[0], hdr_d[1], hdr_d[2], hdr_d[3]};
    word1 = {hdr_d[4], hdr_d[5], hdr_d[6], hdr_d[7]};
    // The box size bounds which compatible brands count; zero means to end of file.
    scan_hit = fresh && (count_d >= COUNT_BITS'(HdrLen)) && (word1 == TagFtyp) &&
               ((count_d == COUNT_BITS'(HdrLen)) ||
                ((count_d >= COUNT_BITS'(20)) && (count_d[1:0] == 2'b00) &&
                 ((word0 == 32'd0) || (CmpW'(count_d) <= CmpW'(word0)))));
    brand_d = brand_q;
    if (scan_hit) begin
      brand_d = brand_q | {is_heic_brand(window_d), is_avif_brand(window_d)};
    end
    flags_o.png  = (count_d >= COUNT_BITS'(8)) && (word0 == TagPng);
    flags_o.jpeg = (count_d >= COUNT_BITS'(3)) && (hdr_d[0] == ChJpg0) &&
                   (hdr_d[1] == ChJpg1) && (hdr_d[2] == ChJpg0);
    flags_o.webp = (count_d >= COUNT_BITS'(4)) && (word0 == TagRiff);
    flags_o.gif  = (count_d >= COUNT_BITS'(4)) && (word0 == TagGif8);
    flags_o.avif = brand_d[0];
    flags_o.heic = brand_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      window_q <= '0;
      brand_q  <= '0;
      for (int i = 0; i < HdrLen; i++) begin
        hdr_q[i] <= '0;
      end
    end else if (step_i) begin
      if (last_i) begin
        count_q  <= '0;
        window_q <= '0;
        brand_q  <= '0;
        for (int i = 0; i < HdrLen; i++) begin
          hdr_q[i] <= '0;
        end
      end else begin
        count_q  <= count_d;
        window_q <= window_d;
        brand_q  <= brand_d;
        hdr_q    <= hdr_d;
      end
    end
  end

  assign count_o  = count_q;
  assign window_o = window_d;

endmodule

/* rtl/ifs_svg_scan.sv */
// SVG text scanner: optional BOM, whitespace skip, then tag match or XML probe.
module ifs_svg_scan #(
  parameter int unsigned SVG_PROBE_WINDOW = ifs_pkg::SVG_PROBE_WINDOW_DEF,
  parameter int unsigned COUNT_BITS       = ifs_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  last_i,
  input  logic [7:0]            data_byte_i,
  input  logic [COUNT_BITS-1:0] pos_i,
  input  logic [31:0]           window_i,
  output logic                  svg_o
);
  import ifs_pkg::*;

  typedef enum logic [2:0] {
    PhStart, PhBom1, PhBom2, PhSkip, PhMatch, PhProbe, PhDone
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] start_q, start_d;
  logic                  found_q, found_d;
  logic [COUNT_BITS-1:0] rel;
  logic [63:0]           rel_ext;
  logic                  is_ws;

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    found_d = found_q;
    rel     = pos_i - start_q;
    rel_ext = 64'(rel);
    is_ws   = (data_byte_i == ChSp) || (data_byte_i == ChTab) ||
              (data_byte_i == ChCr) || (data_byte_i == ChLf);
    unique case (phase_q) inside
      PhStart, PhSkip: begin
        if ((phase_q == PhStart) && (data_byte_i == ChBom0)) begin
          phase_d = PhBom1;
        end else if (is_ws) begin
          phase_d = PhSkip;
        end else if (data_byte_i == ChLt) begin
          start_d = pos_i;
          phase_d = PhMatch;
        end else begin
          phase_d = PhDone;
        end
      end
      PhBom1: phase_d = (data_byte_i == ChBom1) ? PhBom2 : PhDone;
      PhBom2: phase_d = (data_byte_i == ChBom2) ? PhSkip : PhDone;
      PhMatch: begin
        if ((rel_ext == 64'd3) && (window_i == TagSvg)) begin
          found_d = 1'b1;
          phase_d = PhDone;
        end else if (rel_ext >= 64'd4) begin
          phase_d = (window_i == TagXml) ? PhProbe : PhDone;
        end
      end
      PhProbe: begin
        if (rel_ext >= 64'(SVG_PROBE_WINDOW)) begin
          phase_d = PhDone;
        end else if (window_i == TagSvg) begin
          found_d = 1'b1;
          phase_d = PhDone;
        end
      end
      default: phase_d = PhDone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      start_q <= '0;
      found_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PhStart;
        start_q <= '0;
        found_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        start_q <= start_d;
        found_q <= found_d;
      end
    end
  end

  assign svg_o = found_d;

endmodule

/* rtl/image_format_sniffer_unit.sv */
// Top level of the image format sniffer: input register, trackers, result register.
//
//  channel | signals                                  | item
//  --------+------------------------------------------+-------------------------------
//  in      | in_valid_i, in_ready_o, data_byte_i,     | one file byte, last_byte_i
//          | last_byte_i                              | marks the end of the file
//  out     | out_valid_o, out_ready_i, format_code_o  | one format code per file
//
// Each byte passes through the input register before it is folded into the
// tracking state, so one byte is taken every cycle unless a last byte is held back.
// The format code of a file is loaded into the result register when the file's
// last byte moves on from the input register, and the tracking state clears at
// that same edge.
// Reset clears every register but the held byte and its last flag; no clearing pass is needed.
// A waiting result holds back only a last byte, and while that byte waits in
// the input register no new byte is accepted.

`include "image_format_sniffer_unit_assert.svh"

module image_format_sniffer_unit #(
  parameter int unsigned SVG_PROBE_WINDOW = ifs_pkg::SVG_PROBE_WINDOW_DEF,
  parameter int unsigned COUNT_BITS       = ifs_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] format_code_o
);
  import ifs_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Result register.
  logic       out_valid_q;
  ifs_fmt_e   code_q, code_d;

  logic                  step;
  logic [COUNT_BITS-1:0] count;
  logic [31:0]           window;
  ifs_hdr_flags_t        flags;
  logic                  svg_hit;

  // The held byte moves into the trackers unless it ends a file and the
  // previous result has not been taken yet.
  assign step       = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  ifs_hdr_track #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hdr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .last_i      (last_q),
    .data_byte_i (byte_q),
    .count_o     (count),
    .window_o    (window),
    .flags_o     (flags)
  );

  ifs_svg_scan #(
    .SVG_PROBE_WINDOW (SVG_PROBE_WINDOW),
    .COUNT_BITS       (COUNT_BITS)
  ) u_svg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .last_i      (last_q),
    .data_byte_i (byte_q),
    .pos_i       (count),
    .window_i    (window),
    .svg_o       (svg_hit)
  );

  // Magic numbers first, in fixed priority, then brands, then SVG text.
  always_comb begin
    if (flags.png) begin
      code_d = FmtPng;
    end else if (flags.jpeg) begin
      code_d = FmtJpeg;
    end else if (flags.webp) begin
      code_d = FmtWebp;
    end else if (flags.gif) begin
      code_d = FmtGif;
    end else if (flags.avif) begin
      code_d = FmtAvif;
    end else if (flags.heic) begin
      code_d = FmtHeic;
    end else if (svg_hit) begin
      code_d = FmtSvg;
    end else begin
      code_d = FmtNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      code_q      <= FmtNone;
    end else if (step && last_q) begin
      out_valid_q <= 1'b1;
      code_q      <= code_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign format_code_o = code_q;

  // A file's last byte always leaves a result behind.
  `IFS_ASSERT_NEXT(a_last_gives_result, step && last_q, out_valid_q)
  // The byte count restarts after the end of a file.
  `IFS_ASSERT_NEXT(a_count_clears, step && last_q, count == '0)
  // A held byte that cannot move stays in the input register.
  `IFS_ASSERT_NEXT(a_hold_input, in_valid_q && !step, in_valid_q && $stable(byte_q))
  // An unfinished result is never overwritten.
  `IFS_ASSERT_SAME(a_no_overwrite, out_valid_q && !out_ready_i, !(step && last_q))

endmodule

/* dv/tb_image_format_sniffer_unit.sv */
// Self-checking testbench for the image format sniffer: files of bytes in, format codes out.
`timescale 1ns / 100ps

module tb_image_format_sniffer_unit;
  import ifs_pkg::*;

  // The tracker's largest byte count; past it, bytes still feed the window and the
  // text scanner but are no longer recorded as header bytes or brands.
  localparam logic [31:0] CountTop = 32'hFFFF_FFFF;
  localparam int unsigned SvgWindow = SVG_PROBE_WINDOW_DEF;
  // Cycles in a row with no item moving on either channel before the run is abandoned.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ByteTarget = 650;
  localparam int unsigned FileTarget = 20;

  // Phases of the SVG text scanner.
  typedef enum logic [2:0] {
    ScanStart,
    ScanBom1,
    ScanBom2,
    ScanSkip,
    ScanTag,
    ScanProbe,
    ScanDone
  } svg_scan_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } file_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] format_code_o;

  image_format_sniffer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .format_code_o(format_code_o)
  );

  // The clock has a period of 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bytes waiting to be sent, the file being assembled, and the codes the files should get.
  file_byte_t  byte_queue [$];
  logic [7:0]  file_buf [$];
  ifs_fmt_e    expected_codes [$];
  int unsigned files_made = 0;
  int unsigned bytes_taken = 0;
  int unsigned codes_checked = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        byte_handed;

  // Shadow copy of the block's file tracking state.
  logic [31:0] seen_count;
  logic [7:0]  head_mem [HdrLen];
  logic [31:0] tail_word;
  logic [1:0]  brand_seen;
  svg_scan_e   scan_state;
  logic [31:0] tag_pos;
  logic        svg_hit;

  // ---------------------------------------------------------------------------
  // Format prediction
  // ---------------------------------------------------------------------------

  task automatic clear_tracker();
    seen_count = '0;
    foreach (head_mem[i]) head_mem[i] = 8'h00;
    tail_word  = '0;
    brand_seen = 2'b00;
    scan_state = ScanStart;
    tag_pos    = '0;
    svg_hit    = 1'b0;
  endtask

  function automatic logic [31:0] head_word(input int unsigned at);
    return {head_mem[at], head_mem[at+1], head_mem[at+2], head_mem[at+3]};
  endfunction

  // Bit 0 marks an AVIF brand, bit 1 a HEIC family brand.
  function automatic logic [1:0] brand_class(input logic [31:0] w);
    case (w) inside
      "avif", "avis": return 2'b01;
      "heic", "heix", "hevc", "hevx", "heim", "heis", "mif1", "msf1": return 2'b10;
      default: return 2'b00;
    endcase
  endfunction

  // A byte seen where the text may start: whitespace is skipped, '<' opens a tag,
  // anything else rules SVG out.
  task automatic scan_lead(input logic [7:0] b, input logic [31:0] pos);
    if (b == ChSp || b == ChTab || b == ChCr || b == ChLf) begin
      scan_state = ScanSkip;
    end else if (b == ChLt) begin
      tag_pos = pos;
      scan_state = ScanTag;
    end else begin
      scan_state = ScanDone;
    end
  endtask

  function automatic ifs_fmt_e classify();
    if (seen_count >= 8 && head_word(0) == TagPng) return FmtPng;
    if (seen_count >= 3 && head_mem[0] == ChJpg0 && head_mem[1] == ChJpg1 &&
        head_mem[2] == ChJpg0) return FmtJpeg;
    if (seen_count >= 4 && head_word(0) == TagRiff) return FmtWebp;
    if (seen_count >= 4 && head_word(0) == TagGif8) return FmtGif;
    if (brand_seen[0]) return FmtAvif;
    if (brand_seen[1]) return FmtHeic;
    if (svg_hit) return FmtSvg;
    return FmtNone;
  endfunction

  // Folds one accepted byte into the shadow state. The final byte of a file
  // queues the format code the block must report and starts a new file.
  task automatic sniff_byte(input logic [7:0] b, input logic fin);
    logic [31:0] pos;
    logic [31:0] since_lt;
    logic        fresh;
    pos = seen_count;
    fresh = seen_count != CountTop;
    if (fresh) seen_count = seen_count + 1;
    tail_word = {tail_word[23:0], b};
    if (fresh && pos < HdrLen) head_mem[pos] = b;
    // The major brand completes at byte 12; compatible brands complete on every
    // fourth byte from 20 on, as long as they fit in the box.
    if (fresh && seen_count >= 12 && head_word(4) == TagFtyp) begin
      if (seen_count == 12) begin
        brand_seen |= brand_class(tail_word);
      end else if (seen_count >= 20 && seen_count[1:0] == 2'b00 &&
                   (head_word(0) == 0 || seen_count <= head_word(0))) begin
        brand_seen |= brand_class(tail_word);
      end
    end
    since_lt = pos - tag_pos;
    case (scan_state)
      ScanStart: begin
        if (b == ChBom0) scan_state = ScanBom1;
        else scan_lead(b, pos);
      end
      ScanBom1: scan_state = (b == ChBom1) ? ScanBom2 : ScanDone;
      ScanBom2: scan_state = (b == ChBom2) ? ScanSkip : ScanDone;
      ScanSkip: scan_lead(b, pos);
      ScanTag: begin
        if (since_lt == 3 && tail_word == TagSvg) begin
          svg_hit = 1'b1;
          scan_state = ScanDone;
        end else if (since_lt >= 4) begin
          scan_state = (tail_word == TagXml) ? ScanProbe : ScanDone;
        end
      end
      ScanProbe: begin
        if (since_lt >= SvgWindow) begin
          scan_state = ScanDone;
        end else if (tail_word == TagSvg) begin
          svg_hit = 1'b1;
          scan_state = ScanDone;
        end
      end
      default: scan_state = ScanDone;
    endcase
    if (fin) begin
      expected_codes.push_back(classify());
      clear_tracker();
    end
  endtask

  // ---------------------------------------------------------------------------
  // File generation
  // ---------------------------------------------------------------------------

  task automatic put_word(input logic [31:0] w);
    file_buf.push_back(w[31:24]);
    file_buf.push_back(w[23:16]);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(w[7:0]);
  endtask

  task automatic put_noise(input int unsigned n);
    repeat (n) file_buf.push_back(8'($urandom));
  endtask

  // Moves the assembled file into the send queue, marking its final byte.
  task automatic ship_file();
    file_byte_t fb;
    foreach (file_buf[i]) begin
      fb.data = file_buf[i];
      fb.fin  = (i == file_buf.size() - 1);
      byte_queue.push_back(fb);
    end
    file_buf.delete();
    files_made++;
  endtask

  // Brands are drawn mostly from the recognized ones, with some that match nothing.
  function automatic logic [31:0] pick_brand();
    case ($urandom_range(12))
      0: return "avif";
      1: return "avis";
      2: return "heic";
      3: return "heix";
      4: return "hevc";
      5: return "hevx";
      6: return "heim";
      7: return "heis";
      8: return "mif1";
      9: return "msf1";
      10: return "isom";
      11: return "mp41";
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(3))
      0: return ChSp;
      1: return ChTab;
      2: return ChCr;
      default: return ChLf;
    endcase
  endfunction

  // An ISO media file: box size, usually "ftyp", major brand, minor version, compatible
  // brands, and sometimes some trailing bytes past the box.
  task automatic build_box_file();
    int unsigned n_compat;
    logic [31:0] box_len;
    n_compat = $urandom_range(0, 4);
    case ($urandom_range(4))
      0: box_len = 32'd0;
      1: box_len = 16 + 4 * $urandom_range(0, 4);
      2: box_len = 16 + 4 * n_compat;
      3: box_len = $urandom;
      default: box_len = 17 + $urandom_range(0, 20);
    endcase
    put_word(box_len);
    put_word(($urandom_range(7) == 0) ? 32'($urandom) : TagFtyp);
    put_word(pick_brand());
    put_word($urandom);
    repeat (n_compat) put_word(pick_brand());
    if ($urandom_range(2) == 0) put_noise($urandom_range(1, 9));
  endtask

  // Text that may be SVG: an optional byte order mark, which is sometimes broken,
  // some whitespace, then "<svg" or an XML prolog, mostly with "<svg" somewhere after it.
  // A few prologs put the tag right at the edge of the probe window.
  task automatic build_text_file();
    int unsigned gap;
    case ($urandom_range(5))
      0: begin
        file_buf.push_back(ChBom0);
        file_buf.push_back(ChBom1);
        file_buf.push_back(ChBom2);
      end
      1: begin
        file_buf.push_back(ChBom0);
        if ($urandom_range(1) == 0) file_buf.push_back(ChBom1);
        file_buf.push_back(8'($urandom));
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 4)) file_buf.push_back(pick_space());
    if ($urandom_range(9) == 0) put_noise(1);
    if ($urandom_range(2) == 0) begin
      put_word(TagSvg);
    end else begin
      file_buf.push_back(ChLt);
      put_word(TagXml);
      gap = ($urandom_range(5) == 0) ? $urandom_range(244, 252) : $urandom_range(0, 24);
      put_noise(gap);
      if ($urandom_range(4) != 0) put_word(TagSvg);
    end
    put_noise($urandom_range(0, 6));
  endtask

  // Most files are well formed with random content; the rest are noise, have a
  // flipped bit, or are cut short.
  task automatic build_random_file();
    int unsigned pick;
    int unsigned keep;
    pick = $urandom_range(99);
    if (pick < 15) begin
      put_noise($urandom_range(1, 24));
    end else if (pick < 35) begin
      case ($urandom_range(3))
        0: put_word(TagPng);
        1: begin
          file_buf.push_back(ChJpg0);
          file_buf.push_back(ChJpg1);
          file_buf.push_back(ChJpg0);
        end
        2: put_word(TagRiff);
        default: put_word(TagGif8);
      endcase
      put_noise($urandom_range(0, 12));
    end else if (pick < 65) begin
      build_box_file();
    end else begin
      build_text_file();
    end
    if ($urandom_range(5) == 0)
      file_buf[$urandom_range(file_buf.size() - 1)] ^= 8'(1 << $urandom_range(7));
    if ($urandom_range(5) == 0) begin
      keep = $urandom_range(1, file_buf.size());
      while (file_buf.size() > keep) void'(file_buf.pop_back());
    end
    ship_file();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  // The byte on offer always sits at the head of the queue; it is removed and
  // predicted only once the block has taken it. Idling is switched off for a
  // stretch of bytes in the middle of the run.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      byte_handed = in_valid_i && in_ready_o;
      if (byte_handed) begin
        sniff_byte(byte_queue[0].data, byte_queue[0].fin);
        byte_queue.delete(0);
        bytes_taken++;
      end
      if (!in_valid_i || byte_handed) begin
        if (byte_queue.size() != 0 &&
            ((bytes_taken >= 200 && bytes_taken < 330) || $urandom_range(99) >= 30)) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= byte_queue[0].data;
          last_byte_i <= byte_queue[0].fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and checker
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(input string what, input logic [2:0] want,
                              input logic [2:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %0d actual %0d", $realtime, what, want, got);
  endtask

  // Each code the block hands over must match the oldest file still waiting.
  // The receiver stalls at random too, except while a run of files goes through.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_codes.size() == 0) begin
        log_mismatch("format code with no file pending", 3'bx, format_code_o);
      end else begin
        if (format_code_o != expected_codes[0])
          log_mismatch("format code mismatch", expected_codes[0], format_code_o);
        expected_codes.delete(0);
      end
      codes_checked++;
    end
    out_ready_i <= (codes_checked >= 12 && codes_checked < 22) || ($urandom_range(99) >= 30);
  end

  // The watchdog ends a run that has stopped moving.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_tracker();

    // Directed files: each magic number at its minimum length, a broken byte
    // order mark, and an SVG tag behind leading whitespace.
    file_buf = '{ChJpg0, ChJpg1, ChJpg0};
    ship_file();
    put_word(TagRiff);
    ship_file();
    put_word(TagGif8);
    ship_file();
    put_word(TagPng);
    put_word(32'h0D0A1A0A);
    ship_file();
    file_buf = '{ChBom0, 8'h00};
    ship_file();
    file_buf.push_back(ChSp);
    put_word(TagSvg);
    ship_file();

    while (byte_queue.size() < ByteTarget || files_made < FileTarget) build_random_file();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte to go in and every code to come back, then keep watching
    // the output so that any stray result shows.
    while (byte_queue.size() != 0 || in_valid_i || expected_codes.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* image_format_sniffer_unit.f */
+incdir+rtl
rtl/ifs_pkg.sv
rtl/ifs_hdr_track.sv
rtl/ifs_svg_scan.sv
rtl/image_format_sniffer_unit.sv
dv/tb_image_format_sniffer_unit.sv
